### hw/rtl/rtof_pkg.sv
// Shared package for the root tuple obstruction filter.
// Default widths, pipeline latency of the symmetric-sum path, polynomial constants.
// No dependencies.
`timescale 1ns / 1ps

package rtof_pkg;

  localparam int ROOT_WIDTH_DEF = 8;

  // register stages in rtof_sym: five for the sums, five for the polynomial
  localparam int OBST_LAT = 10;

  localparam int K6  = 6;
  localparam int K7  = 7;
  localparam int K8  = 8;
  localparam int K12 = 12;
  localparam int K24 = 24;

  typedef struct packed {
    logic ordered;
    logic normalized;
    logic mirror;
  } rtof_flags_t;

endpackage

### hw/rtl/rtof_gcd.sv
// Pipelined binary gcd of two values, one reduction step per stage.
// A side payload travels alongside. Depends on rtof_pkg.
`timescale 1ns / 1ps

module rtof_gcd import rtof_pkg::*; #(
  parameter int W      = ROOT_WIDTH_DEF,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [W-1:0]      x_in,
  input  logic [W-1:0]      y_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [W-1:0]      g,
  output logic [SIDE_W-1:0] side_out
);

  localparam int STEPS = 2 * W;
  localparam int KW    = $clog2(W + 1);

  logic              vld [1:STEPS];
  logic [W-1:0]      xs  [1:STEPS];
  logic [W-1:0]      ys  [1:STEPS];
  logic [KW-1:0]     ks  [1:STEPS];
  logic [SIDE_W-1:0] sd  [1:STEPS];

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic              vc;
    logic [W-1:0]      xc, yc, xn, yn;
    logic [KW-1:0]     kc, kn;
    logic [SIDE_W-1:0] sc;

    if (i == 0) begin : g_first
      assign vc = in_valid;
      assign xc = x_in;
      assign yc = y_in;
      assign kc = '0;
      assign sc = side_in;
    end else begin : g_rest
      assign vc = vld[i];
      assign xc = xs[i];
      assign yc = ys[i];
      assign kc = ks[i];
      assign sc = sd[i];
    end

    always_comb begin
      xn = xc;
      yn = yc;
      kn = kc;
      if (xc != '0 && yc != '0) begin
        if (!xc[0] && !yc[0]) begin
          xn = xc >> 1;
          yn = yc >> 1;
          kn = kc + 1'b1;
        end else if (!xc[0]) begin
          xn = xc >> 1;
        end else if (!yc[0]) begin
          yn = yc >> 1;
        end else if (xc >= yc) begin
          xn = (xc - yc) >> 1;
        end else begin
          yn = (yc - xc) >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else begin
        vld[i+1] <= vc;
      end
      xs[i+1] <= xn;
      ys[i+1] <= yn;
      ks[i+1] <= kn;
      sd[i+1] <= sc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STEPS];
    end
    g        <= (xs[STEPS] | ys[STEPS]) << ks[STEPS];
    side_out <= sd[STEPS];
  end

endmodule

### hw/rtl/rtof_sym.sv
// Elementary symmetric sums of the roots and exact zero test of the obstruction.
// Ten register stages, arithmetic modulo 2^OW. Depends on rtof_pkg.
`timescale 1ns / 1ps

module rtof_sym import rtof_pkg::*; #(
  parameter int W = ROOT_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic [W-1:0] root_a,
  input  logic [W-1:0] root_b,
  input  logic [W-1:0] root_c,
  input  logic [W-1:0] root_d,
  input  logic [W-1:0] root_e,
  output logic         out_valid,
  output logic         zero
);

  localparam int S1W = W + 3;
  localparam int S2W = 2 * W + 4;
  localparam int S3W = 3 * W + 4;
  localparam int S4W = 4 * W + 3;
  localparam int S5W = 5 * W;
  localparam int OW  = 5 * W + 16;

  logic           v   [0:4];
  logic [W-1:0]   rq  [0:4][0:4];
  logic [S1W-1:0] s1  [0:4];
  logic [S2W-1:0] s2  [0:4];
  logic [S3W-1:0] s3  [0:4];
  logic [S4W-1:0] s4  [0:4];
  logic [S5W-1:0] s5  [0:4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else begin
      v[0] <= in_valid;
    end
    rq[0][0] <= root_a;
    rq[0][1] <= root_b;
    rq[0][2] <= root_c;
    rq[0][3] <= root_d;
    rq[0][4] <= root_e;
    s1[0]    <= S1W'(root_a);
    s2[0]    <= '0;
    s3[0]    <= '0;
    s4[0]    <= '0;
    s5[0]    <= '0;
  end

  for (genvar j = 1; j < 5; j++) begin : g_fold
    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else begin
        v[j] <= v[j-1];
      end
      rq[j] <= rq[j-1];
      s1[j] <= s1[j-1] + S1W'(rq[j-1][j]);
      s2[j] <= s2[j-1] + S2W'(rq[j-1][j]) * S2W'(s1[j-1]);
      s3[j] <= s3[j-1] + S3W'(rq[j-1][j]) * S3W'(s2[j-1]);
      s4[j] <= s4[j-1] + S4W'(rq[j-1][j]) * S4W'(s3[j-1]);
      s5[j] <= s5[j-1] + S5W'(rq[j-1][j]) * S5W'(s4[j-1]);
    end
  end

  // obstruction = s1*(-s1^4 + 6 s1^2 s2 - 7 s1 s3 - 8 s2^2 + 8 s4) + 12 s2 s3 - 24 s5
  logic                 v5, v6, v7, v8;
  logic [2*S1W-1:0]     sq;
  logic [S1W+S3W-1:0]   a1;
  logic [2*S2W-1:0]     b1;
  logic [S2W+S3W-1:0]   c1;
  logic [S1W-1:0]       s1c, s1d, s1e;
  logic [S2W-1:0]       s2c;
  logic [S4W-1:0]       s4c;
  logic [S5W-1:0]       s5c;
  logic [OW-1:0]        q, m, x, c12, c12e, t, o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      v8        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v5        <= v[4];
      v6        <= v5;
      v7        <= v6;
      v8        <= v7;
      out_valid <= v8;
    end
    sq  <= (2*S1W)'(s1[4]) * (2*S1W)'(s1[4]);
    a1  <= (S1W+S3W)'(s1[4]) * (S1W+S3W)'(s3[4]);
    b1  <= (2*S2W)'(s2[4]) * (2*S2W)'(s2[4]);
    c1  <= (S2W+S3W)'(s2[4]) * (S2W+S3W)'(s3[4]);
    s1c <= s1[4];
    s2c <= s2[4];
    s4c <= s4[4];
    s5c <= s5[4];

    q   <= OW'(sq) * OW'(sq);
    m   <= OW'(sq) * OW'(s2c);
    x   <= OW'(K8) * OW'(s4c) - OW'(K8) * OW'(b1) - OW'(K7) * OW'(a1);
    c12 <= OW'(K12) * OW'(c1) - OW'(K24) * OW'(s5c);
    s1d <= s1c;

    t    <= OW'(K6) * m - q + x;
    c12e <= c12;
    s1e  <= s1d;

    o <= OW'(s1e) * t + c12e;

    zero <= (o == '0);
  end

endmodule

### hw/rtl/rtof_delay.sv
// Fixed-depth delay line for a valid bit and a small payload.
// No dependencies beyond rtof_pkg defaults.
`timescale 1ns / 1ps

module rtof_delay import rtof_pkg::*; #(
  parameter int DW    = 1,
  parameter int DEPTH = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] din,
  output logic          out_valid,
  output logic [DW-1:0] dout
);

  logic          vq [0:DEPTH-1];
  logic [DW-1:0] dq [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq[0] <= 1'b0;
    end else begin
      vq[0] <= in_valid;
    end
    dq[0] <= din;
  end

  for (genvar i = 1; i < DEPTH; i++) begin : g_tap
    always_ff @(posedge clk) begin
      if (rst) begin
        vq[i] <= 1'b0;
      end else begin
        vq[i] <= vq[i-1];
      end
      dq[i] <= dq[i-1];
    end
  end

  assign out_valid = vq[DEPTH-1];
  assign dout      = dq[DEPTH-1];

endmodule

### hw/rtl/root_tuple_obstruction_filter.sv
// Top level of the root tuple obstruction filter.
// Uses rtof_pkg, rtof_gcd, rtof_sym, rtof_delay.
//
// channel   | handshake             | payload
// ----------+-----------------------+-------------------------------------------
// request   | start, busy (always 0)| root_a .. root_e
// result    | done (one-cycle pulse)| ordered, primitive_res, normalized,
//           |                       | obstruction_zero, mirror_symmetric, accepted
//
// One request per cycle; each result passes through three chained gcd pipelines of
// 2*ROOT_WIDTH reduction stages each and then the output register. The symmetric-sum
// path is ten stages and is delayed to match.
// Synchronous reset clears the valid bits only. The receiver cannot stall.
`timescale 1ns / 1ps

module root_tuple_obstruction_filter import rtof_pkg::*; #(
  parameter int ROOT_WIDTH = ROOT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ROOT_WIDTH-1:0] root_a,
  input  logic [ROOT_WIDTH-1:0] root_b,
  input  logic [ROOT_WIDTH-1:0] root_c,
  input  logic [ROOT_WIDTH-1:0] root_d,
  input  logic [ROOT_WIDTH-1:0] root_e,
  output logic                  done,
  output logic                  ordered,
  output logic                  primitive_res,
  output logic                  normalized,
  output logic                  obstruction_zero,
  output logic                  mirror_symmetric,
  output logic                  accepted
);

  localparam int W   = ROOT_WIDTH;
  localparam int G   = 2 * W + 1;
  localparam int DLY = 2 * G - OBST_LAT;
  localparam int DW  = W + 2;

  logic        req;
  rtof_flags_t flags_in;

  assign busy = 1'b0;
  assign req  = start && !busy;

  logic signed [DW-1:0] la, lb, lc, ld, ra, rb, rc, rd;
  logic [W:0]           sum_ad, sum_bc;

  always_comb begin
    la = $signed(DW'(root_a));
    lb = $signed(DW'(root_b));
    lc = $signed(DW'(root_c));
    ld = $signed(DW'(root_d));
    ra = $signed(DW'(root_e)) - $signed(DW'(root_d));
    rb = $signed(DW'(root_e)) - $signed(DW'(root_c));
    rc = $signed(DW'(root_e)) - $signed(DW'(root_b));
    rd = $signed(DW'(root_e)) - $signed(DW'(root_a));
    sum_ad = (W+1)'(root_a) + (W+1)'(root_d);
    sum_bc = (W+1)'(root_b) + (W+1)'(root_c);

    flags_in.ordered = (root_a != '0) && (root_a < root_b) && (root_b < root_c) &&
                       (root_c < root_d) && (root_d < root_e);
    if (la != ra) begin
      flags_in.normalized = la < ra;
    end else if (lb != rb) begin
      flags_in.normalized = lb < rb;
    end else if (lc != rc) begin
      flags_in.normalized = lc < rc;
    end else if (ld != rd) begin
      flags_in.normalized = ld < rd;
    end else begin
      flags_in.normalized = 1'b1;
    end
    flags_in.mirror = (sum_ad == (W+1)'(root_e)) && (sum_bc == (W+1)'(root_e));
  end

  // first gcd level
  logic         v_ab, v_cd;
  logic [W-1:0] g_ab, g_cd, e_ab;
  rtof_flags_t  flags_cd;

  rtof_gcd #(.W(W), .SIDE_W(W)) u_gcd_ab (
    .clk, .rst, .in_valid(req), .x_in(root_a), .y_in(root_b), .side_in(root_e),
    .out_valid(v_ab), .g(g_ab), .side_out(e_ab)
  );

  rtof_gcd #(.W(W), .SIDE_W($bits(rtof_flags_t))) u_gcd_cd (
    .clk, .rst, .in_valid(req), .x_in(root_c), .y_in(root_d), .side_in(flags_in),
    .out_valid(v_cd), .g(g_cd), .side_out(flags_cd)
  );

  // second level
  logic         v_2;
  logic [W-1:0] g_2, e_2;
  rtof_flags_t  flags_2;

  rtof_gcd #(.W(W), .SIDE_W(W + $bits(rtof_flags_t))) u_gcd_2 (
    .clk, .rst, .in_valid(v_ab && v_cd), .x_in(g_ab), .y_in(g_cd),
    .side_in({e_ab, flags_cd}),
    .out_valid(v_2), .g(g_2), .side_out({e_2, flags_2})
  );

  // symmetric sums and obstruction, aligned to the third level
  logic sym_valid, sym_zero, obz_valid, obz;

  rtof_sym #(.W(W)) u_sym (
    .clk, .rst, .in_valid(req),
    .root_a, .root_b, .root_c, .root_d, .root_e,
    .out_valid(sym_valid), .zero(sym_zero)
  );

  rtof_delay #(.DW(1), .DEPTH(DLY)) u_dly (
    .clk, .rst, .in_valid(sym_valid), .din(sym_zero),
    .out_valid(obz_valid), .dout(obz)
  );

  // third level
  logic         v_3, obz_3;
  logic [W-1:0] g_3;
  rtof_flags_t  flags_3;

  rtof_gcd #(.W(W), .SIDE_W($bits(rtof_flags_t) + 1)) u_gcd_3 (
    .clk, .rst, .in_valid(v_2 && obz_valid), .x_in(g_2), .y_in(e_2),
    .side_in({flags_2, obz}),
    .out_valid(v_3), .g(g_3), .side_out({flags_3, obz_3})
  );

  logic prim;
  assign prim = (g_3 == W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_3;
    end
    ordered          <= flags_3.ordered;
    primitive_res    <= prim;
    normalized       <= flags_3.normalized;
    obstruction_zero <= obz_3;
    mirror_symmetric <= flags_3.mirror;
    accepted         <= flags_3.ordered && prim && flags_3.normalized && obz_3;
  end

endmodule

### hw/rtl/rtof_checker.sv
// Port-level checks for root_tuple_obstruction_filter, attached by bind.
// Depends on rtof_pkg and the top level's port list.
`timescale 1ns / 1ps

module rtof_checker import rtof_pkg::*; #(
  parameter int ROOT_WIDTH = ROOT_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic [ROOT_WIDTH-1:0] root_a,
  input logic [ROOT_WIDTH-1:0] root_b,
  input logic [ROOT_WIDTH-1:0] root_c,
  input logic [ROOT_WIDTH-1:0] root_d,
  input logic [ROOT_WIDTH-1:0] root_e,
  input logic                  done,
  input logic                  ordered,
  input logic                  primitive_res,
  input logic                  normalized,
  input logic                  obstruction_zero,
  input logic                  mirror_symmetric,
  input logic                  accepted
);

  localparam int LAT = 3 * (2 * ROOT_WIDTH + 1) + 1;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##LAT done)
    else $error("request without result at fixed latency");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching request");

  a_accept_and: assert property (@(posedge clk) disable iff (rst)
    done && accepted |-> ordered && primitive_res && normalized && obstruction_zero)
    else $error("accepted without all its conditions");

  a_mirror_norm: assert property (@(posedge clk) disable iff (rst)
    done && mirror_symmetric |-> normalized)
    else $error("mirror symmetric tuple not normalized");

endmodule

bind root_tuple_obstruction_filter rtof_checker #(.ROOT_WIDTH(ROOT_WIDTH)) u_chk (.*);
